// File: rtl/csgt_pkg.sv
// Package for the centroid swipe gesture tracker.
// Field widths, register indexes, reset values, gesture codes and stage control types.
// Depends on nothing; every module of the block imports it.
package csgt_pkg;

  localparam int THR_W     = 12;
  localparam int MSL_W     = 12;
  localparam int SF_W      = 8;
  localparam int SETTLE_W  = 9;
  localparam int GESTURE_W = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam logic [THR_W-1:0] MOVE_THR_RST  = 12'd14;
  localparam logic [MSL_W-1:0] MIN_SWEEP_RST = 12'd100;
  localparam logic [SF_W-1:0]  SETTLE_RST    = 8'd1;

  typedef enum logic [1:0] {
    REG_MOVE_THR  = 2'd0,
    REG_MIN_SWEEP = 2'd1,
    REG_SETTLE    = 2'd2
  } reg_idx_e;

  typedef enum logic [GESTURE_W-1:0] {
    GEST_NONE       = 3'd0,
    GEST_RIGHT_LEFT = 3'd1,
    GEST_LEFT_RIGHT = 3'd2,
    GEST_BOTTOM_UP  = 3'd3,
    GEST_TOP_DOWN   = 3'd4
  } gesture_e;

  typedef struct packed {
    logic valid;
    logic fire;
  } trk_ctl_t;

endpackage

// File: rtl/csgt_regs.sv
// Configuration registers of the swipe tracker behind an APB-style port.
// Holds move threshold, minimum sweep length and settle frame count; uses csgt_pkg.
module csgt_regs
  import csgt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [THR_W-1:0]  move_thr_o,
  output logic [MSL_W-1:0]  min_sweep_o,
  output logic [SF_W-1:0]   settle_frames_o
);

  logic [THR_W-1:0] move_thr_q;
  logic [MSL_W-1:0] min_sweep_q;
  logic [SF_W-1:0]  settle_q;
  logic             wr_en;
  logic [1:0]       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_thr_q  <= MOVE_THR_RST;
      min_sweep_q <= MIN_SWEEP_RST;
      settle_q    <= SETTLE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MOVE_THR:  move_thr_q  <= pwdata[THR_W-1:0];
        REG_MIN_SWEEP: min_sweep_q <= pwdata[MSL_W-1:0];
        REG_SETTLE:    settle_q    <= pwdata[SF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MOVE_THR:  prdata = APB_DW'(move_thr_q);
      REG_MIN_SWEEP: prdata = APB_DW'(min_sweep_q);
      REG_SETTLE:    prdata = APB_DW'(settle_q);
      default:       prdata = '0;
    endcase
  end

  assign move_thr_o      = move_thr_q;
  assign min_sweep_o     = min_sweep_q;
  assign settle_frames_o = settle_q;

endmodule

// File: rtl/csgt_track.sv
// Input register, tracking state and move detection of the swipe tracker.
// Hands the sweep vector and a classify flag to csgt_classify; uses csgt_pkg.
module csgt_track
  import csgt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_BITS-1:0]   pos_x_i,
  input  logic [COORD_BITS-1:0]   pos_y_i,
  input  logic [THR_W-1:0]        move_thr_i,
  input  logic [SF_W-1:0]         settle_frames_i,
  input  logic                    cls_ready_i,
  output trk_ctl_t                ctl_o,
  output logic signed [COORD_BITS+1:0] dx_o,
  output logic signed [COORD_BITS+1:0] dy_o
);

  localparam int PW  = COORD_BITS + 1;
  localparam int DW  = COORD_BITS + 2;
  localparam int SQW = (2 * DW > 2 * THR_W) ? 2 * DW : 2 * THR_W;

  logic                         s0_valid_q;
  logic [COORD_BITS-1:0]        px_q, py_q;
  logic                         s0_ready, s0_go;

  logic signed [PW-1:0]         prev_x_q, prev_y_q, start_x_q, start_y_q;
  logic                         tracking_q;
  logic signed [SETTLE_W-1:0]   settle_q;

  logic                         s1_valid_q, s1_fire_q;
  logic signed [DW-1:0]         dx_q, dy_q;
  logic                         s1_ready;

  logic                         frame_ok, move, settled, fire;
  logic signed [DW-1:0]         sx, sy, ex, ey;
  logic signed [2*DW-1:0]       sx2, sy2;
  logic [SQW-1:0]               step2;
  logic [2*THR_W-1:0]           thr_sq;
  logic signed [SETTLE_W-1:0]   sf_s;

  assign s1_ready   = !s1_valid_q || cls_ready_i;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign s0_go      = s0_valid_q && s1_ready;
  assign in_stall_o = !s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  assign frame_ok = (px_q != '0) && (py_q != '0);
  assign sx       = $signed({2'b00, px_q}) - $signed({prev_x_q[PW-1], prev_x_q});
  assign sy       = $signed({2'b00, py_q}) - $signed({prev_y_q[PW-1], prev_y_q});
  assign sx2      = sx * sx;
  assign sy2      = sy * sy;
  assign step2    = SQW'($unsigned(sx2)) + SQW'($unsigned(sy2));
  assign thr_sq   = move_thr_i * move_thr_i;
  assign move     = frame_ok && (step2 > SQW'(thr_sq));
  assign sf_s     = $signed({1'b0, settle_frames_i});
  assign settled  = !(settle_q < sf_s);
  assign fire     = frame_ok && !move && tracking_q && settled;
  assign ex       = $signed({2'b00, px_q}) - $signed({start_x_q[PW-1], start_x_q});
  assign ey       = $signed({2'b00, py_q}) - $signed({start_y_q[PW-1], start_y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q   <= '1;
      prev_y_q   <= '1;
      start_x_q  <= '0;
      start_y_q  <= '0;
      tracking_q <= 1'b0;
      settle_q   <= '1;
    end else if (s0_go && frame_ok) begin
      if (move) begin
        if (!tracking_q) begin
          start_x_q  <= prev_x_q;
          start_y_q  <= prev_y_q;
          tracking_q <= 1'b1;
          settle_q   <= settle_q + SETTLE_W'(1);
        end else begin
          settle_q   <= '1;
        end
        prev_x_q <= $signed({1'b0, px_q});
        prev_y_q <= $signed({1'b0, py_q});
      end else if (tracking_q) begin
        if (!settled) begin
          settle_q   <= settle_q + SETTLE_W'(1);
        end else begin
          tracking_q <= 1'b0;
          settle_q   <= '1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_go) begin
      s1_fire_q <= fire;
      dx_q      <= ex;
      dy_q      <= ey;
    end
  end

  assign ctl_o.valid = s1_valid_q;
  assign ctl_o.fire  = s1_fire_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;

`ifndef SYNTHESIS
  a_idle_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tracking_q |-> settle_q == '1)
    else $error("settle count not cleared while idle");

  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fire_q) |-> !tracking_q)
    else $error("tracking still set after classify beat");

  a_start_only_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tracking_q) |-> $past(s0_go && move))
    else $error("tracking started without a move");
`endif

endmodule

// File: rtl/csgt_classify.sv
// Swipe classification and output register of the swipe tracker.
// Squares the sweep vector, tests the 30 degree sectors; uses csgt_pkg.
module csgt_classify
  import csgt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  trk_ctl_t                     ctl_i,
  input  logic signed [COORD_BITS+1:0] dx_i,
  input  logic signed [COORD_BITS+1:0] dy_i,
  input  logic [MSL_W-1:0]             min_sweep_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         decided_o,
  output logic [GESTURE_W-1:0]         gesture_o
);

  localparam int DW = COORD_BITS + 2;
  localparam int QW = (2 * DW > 2 * MSL_W) ? 2 * DW : 2 * MSL_W;
  localparam int CW = QW + 3;

  logic signed [2*DW-1:0]  dx2_s, dy2_s;
  logic [CW-1:0]           dx2, dy2, d2, d2x3, dx2x4, dy2x4;
  logic [2*MSL_W-1:0]      msl_sq;
  logic                    too_short, horiz, vert;
  gesture_e                gest;

  logic                    out_valid_q, decided_q;
  gesture_e                gesture_q;

  assign dx2_s  = dx_i * dx_i;
  assign dy2_s  = dy_i * dy_i;
  assign dx2    = CW'($unsigned(dx2_s));
  assign dy2    = CW'($unsigned(dy2_s));
  assign d2     = dx2 + dy2;
  assign d2x3   = (d2 << 1) + d2;
  assign dx2x4  = dx2 << 2;
  assign dy2x4  = dy2 << 2;
  assign msl_sq = min_sweep_i * min_sweep_i;

  assign too_short = d2 < CW'(msl_sq);
  assign horiz     = (dx2x4 >= d2x3) && (dy2x4 <= d2);
  assign vert      = (dy2x4 >= d2x3) && (dx2x4 <= d2);

  always_comb begin
    if (!ctl_i.fire || too_short) begin
      gest = GEST_NONE;
    end else if (horiz) begin
      gest = (dx_i > 0) ? GEST_RIGHT_LEFT : GEST_LEFT_RIGHT;
    end else if (vert) begin
      gest = (dy_i < 0) ? GEST_BOTTOM_UP : GEST_TOP_DOWN;
    end else begin
      gest = GEST_NONE;
    end
  end

  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      decided_q <= ctl_i.fire;
      gesture_q <= gest;
    end
  end

  assign out_valid_o = out_valid_q;
  assign decided_o   = decided_q;
  assign gesture_o   = gesture_q;

`ifndef SYNTHESIS
  a_none_when_undecided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !decided_q) |-> gesture_q == GEST_NONE)
    else $error("gesture reported without a decision");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(decided_q)
                                      && $stable(gesture_q)))
    else $error("output beat changed while stalled");
`endif

endmodule

// File: rtl/centroid_swipe_gesture_tracker.sv
// Top level of the centroid swipe gesture tracker.
// Instantiates csgt_regs, csgt_track and csgt_classify; uses csgt_pkg.
//
// Usage:
//   Input channel: one centroid beat per frame on pos_x_i/pos_y_i with
//   in_valid_i; the beat is taken when in_valid_i is high and in_stall_o low.
//   Output channel: one result beat per input beat on decided_o/gesture_o
//   with out_valid_o; taken when out_valid_o is high and out_stall_i low.
//   Configuration: APB-style port, move threshold at 0x0, minimum sweep
//   length at 0x4, settle frames at 0x8; write only while no beat is in flight.
//   Path: a taken beat passes the input register, the tracking register and
//   the output register in turn. Throughput: one beat per cycle while no stall
//   holds it; the step square and threshold compare feed the tracking state update.
//   Reset: all stages empty, tracking idle, registers at their defaults.
//   Stall: the output register holds its beat; the input and tracking stages
//   keep filling, then in_stall_o rises once all three stages are full.
module centroid_swipe_gesture_tracker
  import csgt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  decided_o,
  output logic [GESTURE_W-1:0]  gesture_o
);

  logic [THR_W-1:0]             move_thr;
  logic [MSL_W-1:0]             min_sweep;
  logic [SF_W-1:0]              settle_frames;
  logic                         cls_ready;
  trk_ctl_t                     ctl;
  logic signed [COORD_BITS+1:0] dx, dy;

  csgt_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .move_thr_o      (move_thr),
    .min_sweep_o     (min_sweep),
    .settle_frames_o (settle_frames)
  );

  csgt_track #(
    .COORD_BITS (COORD_BITS)
  ) u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .move_thr_i      (move_thr),
    .settle_frames_i (settle_frames),
    .cls_ready_i     (cls_ready),
    .ctl_o           (ctl),
    .dx_o            (dx),
    .dy_o            (dy)
  );

  csgt_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .dx_i        (dx),
    .dy_i        (dy),
    .min_sweep_i (min_sweep),
    .ready_o     (cls_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .decided_o   (decided_o),
    .gesture_o   (gesture_o)
  );

endmodule
